@@ rtl/biq_pkg.sv @@
`default_nettype none
package biq_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int COEF_FRAC = 21;
  localparam int FB_FRAC   = 8;
  localparam int FB_W      = 32;
  localparam int ORDER_W   = 2;
  localparam int CFG_IDX_W = 3;

  // product and accumulator widths
  localparam int FF_PROD_W = SAMPLE_W + COEF_W;
  localparam int FF_W      = FF_PROD_W + 2;
  localparam int FB_PROD_W = FB_W + COEF_W;
  localparam int FB_SUM_W  = FB_PROD_W + 1;
  localparam int ACC_W     = FB_SUM_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd5;

  localparam logic [ORDER_W-1:0] ORDER_ONE = 2'd1;
  localparam logic [ORDER_W-1:0] ORDER_TWO = 2'd2;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [ORDER_W-1:0]       order;
  } coef_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/iir_biquad_direct_form_one.sv @@
// channel | dir | handshake         | payload
// in      | in  | in_valid/in_ready | in_sample[15:0] signed
// out     | out | out_valid/out_ready | out_filtered[15:0] signed, out_clipped
// cfg     | in  | cfg_valid/cfg_ready | cfg_index[2:0], cfg_data[23:0]
//
// One sample per cycle sustained unless out_ready stalls the result.
// The five products and the sum run between the input register and the
// result register, with the y[n-1] feedback closing through that same pass.
// Reset clears both histories and loads the coefficient defaults.
// A stalled result holds while one more beat waits in the input register.
// cfg_ready is always high.
`default_nettype none
module iir_biquad_direct_form_one
  import biq_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      out_filtered,
  output logic                            out_clipped,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [COEF_W-1:0]          cfg_data
);

  coef_t                      coef;
  result_t                    res;
  logic                       in_valid_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       out_valid_r;
  result_t                    res_r;
  logic                       advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;

  biq_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .coef     (coef)
  );

  biq_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .x     (sample_r),
    .coef  (coef),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the result while the sink stalls
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = res_r.filtered;
  assign out_clipped  = res_r.clipped;

endmodule
`default_nettype wire

@@ rtl/biq_cfg.sv @@
`default_nettype none
module biq_cfg
  import biq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [COEF_W-1:0]    wr_data,
  output coef_t                     coef
);

  coef_t coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0    <= COEF_ONE;
      coef_r.b1    <= '0;
      coef_r.b2    <= '0;
      coef_r.a1    <= '0;
      coef_r.a2    <= '0;
      coef_r.order <= ORDER_TWO;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_B0:    coef_r.b0    <= wr_data;
        REG_B1:    coef_r.b1    <= wr_data;
        REG_B2:    coef_r.b2    <= wr_data;
        REG_A1:    coef_r.a1    <= wr_data;
        REG_A2:    coef_r.a2    <= wr_data;
        REG_ORDER: coef_r.order <= wr_data[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  assign coef = coef_r;

endmodule
`default_nettype wire

@@ rtl/biq_dp.sv @@
`default_nettype none
module biq_dp
  import biq_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic signed [SAMPLE_W-1:0] x,
  input  wire coef_t                      coef,
  output result_t                         res
);

  localparam logic signed [ACC_W-1:0] Y_BIAS =
    {{(ACC_W-COEF_FRAC){1'b0}}, {COEF_FRAC{1'b1}}};
  localparam logic signed [ACC_W-1:0] Q_BIAS =
    {{(ACC_W-COEF_FRAC-FB_FRAC){1'b0}}, {(COEF_FRAC+FB_FRAC){1'b1}}};

  logic signed [SAMPLE_W-1:0]  x1_r, x2_r;
  logic signed [FB_W-1:0]      y1_r, y2_r;

  logic                        second;
  logic signed [FF_PROD_W-1:0] p_b0, p_b1, p_b2;
  logic signed [FB_PROD_W-1:0] p_a1, p_a2;
  logic signed [FF_W-1:0]      ff;
  logic signed [FB_SUM_W-1:0]  fb;
  logic signed [ACC_W-1:0]     acc, acc_y, acc_q, yq, qq;
  logic                        y_ok, q_ok;
  logic signed [FB_W-1:0]      y_nxt;
  logic signed [SAMPLE_W-1:0]  q;

  assign second = (coef.order != ORDER_ONE);

  always_comb begin
    p_b0 = FF_PROD_W'(x)    * FF_PROD_W'(coef.b0);
    p_b1 = FF_PROD_W'(x1_r) * FF_PROD_W'(coef.b1);
    p_b2 = second ? FF_PROD_W'(x2_r) * FF_PROD_W'(coef.b2) : '0;
    p_a1 = FB_PROD_W'(y1_r) * FB_PROD_W'(coef.a1);
    p_a2 = second ? FB_PROD_W'(y2_r) * FB_PROD_W'(coef.a2) : '0;

    ff  = FF_W'(p_b0) + FF_W'(p_b1) + FF_W'(p_b2);
    fb  = FB_SUM_W'(p_a1) + FB_SUM_W'(p_a2);
    acc = (ACC_W'(ff) <<< FB_FRAC) - ACC_W'(fb);

    // truncate toward zero: bias negative values before the shift
    acc_y = acc[ACC_W-1] ? acc + Y_BIAS : acc;
    acc_q = acc[ACC_W-1] ? acc + Q_BIAS : acc;
    yq    = acc_y >>> COEF_FRAC;
    qq    = acc_q >>> (COEF_FRAC + FB_FRAC);

    y_ok = (&yq[ACC_W-1:FB_W-1]) || !(|yq[ACC_W-1:FB_W-1]);
    q_ok = (&qq[ACC_W-1:SAMPLE_W-1]) || !(|qq[ACC_W-1:SAMPLE_W-1]);

    if (y_ok) begin
      y_nxt = yq[FB_W-1:0];
    end else begin
      y_nxt = yq[ACC_W-1] ? {1'b1, {(FB_W-1){1'b0}}} : {1'b0, {(FB_W-1){1'b1}}};
    end

    if (q_ok) begin
      q = qq[SAMPLE_W-1:0];
    end else begin
      q = qq[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end

    res.filtered = q;
    res.clipped  = !y_ok || !q_ok;
  end

  // advance both histories on every sample, whatever the order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (en) begin
      x1_r <= x;
      x2_r <= x1_r;
      y1_r <= y_nxt;
      y2_r <= y1_r;
    end
  end

endmodule
`default_nettype wire

@@ rtl/biq_chk.sv @@
`default_nettype none
module biq_chk
  import biq_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic signed [SAMPLE_W-1:0] out_filtered,
  input wire logic                       out_clipped,
  input wire logic                       cfg_valid,
  input wire logic                       cfg_ready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered) && $stable(out_clipped))
    else $error("result beat changed while stalled");

  // input backs up only when the result register is full and stalled
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // reset drops any pending result
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an idle block with nothing in flight takes input at once
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready with empty output");

  // configuration never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind iir_biquad_direct_form_one biq_chk u_biq_chk (.*);
`default_nettype wire
